// ----- hdl/hhdr_pkg.sv -----
// Shared types, widths and constants for the heading hold and dead reckoning core.
`timescale 1ns / 1ps

package hhdr_pkg;

   // field widths
   localparam int GYRO_W       = 16;
   localparam int ACCEL_W      = 16;
   localparam int PULSE_W      = 15;
   localparam int TICKS_W      = 16;
   localparam int YAW_W        = 25;
   localparam int SPEED_W      = 32;
   localparam int DIST_W       = 32;
   localparam int YAW_STEP_W   = 22;
   localparam int SPEED_STEP_W = 19;

   // stream payloads
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 104;
   localparam int TICKS_LSB   = 0;
   localparam int HEADING_LSB = 16;
   localparam int TRAVEL_LSB  = 41;
   localparam int MEAN_LSB    = 73;
   localparam int MOVING_BIT  = 98;
   localparam int LAMP_BIT    = 99;

   // register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int DEFAULT_WINDOW_DEPTH = 10;

   typedef enum logic [1:0] {
      REG_GYRO_BIAS,
      REG_ACCEL_BIAS,
      REG_PULSE_MIN,
      REG_PULSE_MAX
   } reg_index_type;

   localparam logic [PULSE_W-1:0] PULSE_MIN_RESET = 15'd500;
   localparam logic [PULSE_W-1:0] PULSE_MAX_RESET = 15'd2550;

   // thresholds on bias-corrected magnitudes
   localparam logic [15:0] GYRO_DEADBAND  = 16'd13;
   localparam logic [15:0] GYRO_MOVE_MIN  = 16'd79;
   localparam logic [15:0] ACCEL_MOVE_MIN = 16'd1311;
   localparam logic [15:0] ACCEL_DEADBAND = 16'd334;

   // yaw step = round(|d| * 16384 / 655) = floor((|d| * 16384 + 327) / 655)
   localparam int YAW_NUM_W = 30;
   localparam int YAW_SHIFT = 40;
   localparam int YAW_Q_W   = 21;
   localparam logic [YAW_NUM_W-1:0] YAW_NUM_OFFS = 30'd327;
   localparam logic [30:0] YAW_RECIP = 31'(((64'd1 << YAW_SHIFT) + 64'd654) / 64'd655);

   // speed step = floor((|e| * 196133 + 50000) / 32 / 3125)
   localparam int ACCEL_NUM_W    = 34;
   localparam int ACCEL_PRESHIFT = 5;
   localparam int ACCEL_Y_W      = 29;
   localparam int ACCEL_SHIFT    = 41;
   localparam int ACCEL_Q_W      = 18;
   localparam logic [17:0] ACCEL_GAIN = 18'd196133;
   localparam logic [ACCEL_NUM_W-1:0] ACCEL_OFFS = 34'd50000;
   localparam logic [29:0] ACCEL_RECIP =
      30'(((64'd1 << ACCEL_SHIFT) + 64'd3124) / 64'd3125);

   localparam logic signed [YAW_W:0]   YAW_HALF_TURN  = 26'sd11796480;
   localparam logic signed [YAW_W:0]   YAW_FULL_TURN  = 26'sd23592960;
   localparam logic signed [YAW_W-1:0] YAW_LAMP_LIMIT = 25'sd4849664;

   localparam logic signed [SPEED_W-1:0] SPEED_FLOOR = 32'sd65;
   localparam int SERVO_SHIFT = 16;

   // per-beat increments handed from the front end to the integrators
   typedef struct packed {
      logic signed [YAW_STEP_W-1:0]   yaw_step;
      logic signed [SPEED_STEP_W-1:0] speed_step;
      logic                           moving;
      logic [PULSE_W-1:0]             base_us;
   } step_type;

endpackage

// ----- hdl/hhdr_step.sv -----
// Two-stage front end: bias removal, deadbands, motion flag and scaled yaw and speed steps.
`timescale 1ns / 1ps

module hhdr_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [hhdr_pkg::GYRO_W-1:0]  gyro_raw,
   input  logic signed [hhdr_pkg::ACCEL_W-1:0] accel_raw,
   input  logic [hhdr_pkg::PULSE_W-1:0]        base_pulse_us,
   input  logic signed [hhdr_pkg::GYRO_W-1:0]  gyro_bias,
   input  logic signed [hhdr_pkg::ACCEL_W-1:0] accel_bias,
   output logic                                out_valid,
   input  logic                                out_ready,
   output hhdr_pkg::step_type                  out_step
);
   import hhdr_pkg::*;

   logic signed [GYRO_W:0]  gyro_diff;
   logic signed [ACCEL_W:0] accel_diff;
   logic [GYRO_W:0]         gyro_abs;
   logic [ACCEL_W:0]        accel_abs;
   logic [15:0]             gyro_mag;
   logic [15:0]             accel_mag;
   logic [YAW_NUM_W-1:0]    yaw_num;
   logic [YAW_NUM_W+30:0]   yaw_prod;
   logic [ACCEL_NUM_W-1:0]  accel_num;

   logic                    s1_valid_ff;
   logic [YAW_Q_W-1:0]      s1_yaw_q_ff;
   logic                    s1_yaw_neg_ff;
   logic                    s1_yaw_en_ff;
   logic [ACCEL_Y_W-1:0]    s1_accel_y_ff;
   logic                    s1_accel_neg_ff;
   logic                    s1_accel_en_ff;
   logic                    s1_moving_ff;
   logic [PULSE_W-1:0]      s1_base_ff;

   logic [ACCEL_Y_W+29:0]   accel_prod;
   logic [ACCEL_Q_W-1:0]    accel_q;
   logic [YAW_STEP_W-1:0]   yaw_mag;
   logic [SPEED_STEP_W-1:0] speed_mag;
   step_type                step_in;
   step_type                step_ff;
   logic                    s2_valid_ff;
   logic                    s1_ready;
   logic                    s2_ready;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // stage 1: bias removal and the first multiply of each path
   assign gyro_diff  = $signed({gyro_raw[GYRO_W-1], gyro_raw})
                     - $signed({gyro_bias[GYRO_W-1], gyro_bias});
   assign accel_diff = $signed({accel_raw[ACCEL_W-1], accel_raw})
                     - $signed({accel_bias[ACCEL_W-1], accel_bias});
   assign gyro_abs   = gyro_diff[GYRO_W] ? -gyro_diff : gyro_diff;
   assign accel_abs  = accel_diff[ACCEL_W] ? -accel_diff : accel_diff;
   // magnitude never exceeds 65535
   assign gyro_mag   = gyro_abs[15:0];
   assign accel_mag  = accel_abs[15:0];

   assign yaw_num   = {gyro_mag, 14'd0} + YAW_NUM_OFFS;
   assign yaw_prod  = yaw_num * YAW_RECIP;
   assign accel_num = accel_mag * ACCEL_GAIN + ACCEL_OFFS;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_yaw_q_ff     <= yaw_prod[YAW_SHIFT +: YAW_Q_W];
         s1_yaw_neg_ff   <= gyro_diff[GYRO_W];
         s1_yaw_en_ff    <= gyro_mag > GYRO_DEADBAND;
         s1_accel_y_ff   <= accel_num[ACCEL_PRESHIFT +: ACCEL_Y_W];
         s1_accel_neg_ff <= accel_diff[ACCEL_W];
         s1_accel_en_ff  <= accel_mag > ACCEL_DEADBAND;
         s1_moving_ff    <= (accel_mag >= ACCEL_MOVE_MIN) || (gyro_mag >= GYRO_MOVE_MIN);
         s1_base_ff      <= base_pulse_us;
      end
   end

   // stage 2: divide by 3125 via reciprocal, apply signs and deadbands
   assign accel_prod = s1_accel_y_ff * ACCEL_RECIP;
   assign accel_q    = accel_prod[ACCEL_SHIFT +: ACCEL_Q_W];
   assign yaw_mag    = {1'b0, s1_yaw_q_ff};
   assign speed_mag  = {1'b0, accel_q};

   always_comb begin
      step_in            = step_ff;
      step_in.yaw_step   = '0;
      step_in.speed_step = '0;
      if (s1_yaw_en_ff) begin
         step_in.yaw_step = s1_yaw_neg_ff ? -yaw_mag : yaw_mag;
      end
      if (s1_accel_en_ff) begin
         step_in.speed_step = s1_accel_neg_ff ? -speed_mag : speed_mag;
      end
      step_in.moving  = s1_moving_ff;
      step_in.base_us = s1_base_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         step_ff <= step_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_step  = step_ff;

endmodule

// ----- hdl/heading_hold_dead_reckoning_core.sv -----
// Top level of the heading hold and dead reckoning core: integrators, yaw ring and servo output.
//
// One request beat carries a gyro Z sample, an accelerometer X sample and a servo centre
// pulse; each one yields exactly one response beat with servo ticks, heading, travelled
// distance, the windowed heading mean and the moving and lamp flags, in request order.
// The datapath is a four-register pipeline (two front-end stages, the integrator stage,
// the output register). A beat passes both front-end stages and the integrator stage to the
// output register behind rsp_tvalid, and one beat per cycle is sustained while rsp_tready is
// high; the integrators and the ring total are updated once per beat in the integrator stage,
// which is what bounds the rate to one. When the receiver stalls, each stage still fills
// while the one below it holds, so up to four beats are taken before req_tready drops.
// The CSR port sets the gyro and accel biases and the pulse limits; write it only while
// the pipeline is empty. Reset clears the registers to their defaults, the yaw, speed
// and distance integrators, the yaw ring, its index and the latched mean, and empties
// the pipeline. The mean is recomputed whenever the ring index is at slot zero.
`timescale 1ns / 1ps

module heading_hold_dead_reckoning_core #(
   parameter int WINDOW_DEPTH = hhdr_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: gyro_raw[15:0], accel_raw[31:16], base_pulse_us[46:32], zero pad [47]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hhdr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // rsp_tdata: servo_ticks[15:0], heading[40:16], travel_cm[72:41], heading_mean[97:73],
   //            moving[98], lamp_on[99], zero pad [103:100]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hhdr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [hhdr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [hhdr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [hhdr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import hhdr_pkg::*;

   localparam int IDX_W      = $clog2(WINDOW_DEPTH);
   localparam int SUM_W      = YAW_W + $clog2(WINDOW_DEPTH);
   localparam int MEAN_X_W   = SUM_W + 1;
   localparam int MEAN_DIV   = 2 * WINDOW_DEPTH;
   localparam int MEAN_SHIFT = MEAN_X_W + $clog2(MEAN_DIV);
   localparam int MEAN_K_W   = MEAN_X_W + 1;
   localparam logic [MEAN_K_W-1:0] MEAN_RECIP =
      MEAN_K_W'(((64'd1 << MEAN_SHIFT) + 64'(MEAN_DIV) - 64'd1) / 64'(MEAN_DIV));
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_DEPTH - 1);

   // ---------------------------------------------------------------- CSRs
   logic signed [GYRO_W-1:0]  gyro_bias_ff;
   logic signed [ACCEL_W-1:0] accel_bias_ff;
   logic [PULSE_W-1:0]        pulse_min_ff;
   logic [PULSE_W-1:0]        pulse_max_ff;
   logic                      csr_write;
   reg_index_type             csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_bias_ff  <= '0;
         accel_bias_ff <= '0;
         pulse_min_ff  <= PULSE_MIN_RESET;
         pulse_max_ff  <= PULSE_MAX_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_GYRO_BIAS:  gyro_bias_ff  <= csr_pwdata[GYRO_W-1:0];
            REG_ACCEL_BIAS: accel_bias_ff <= csr_pwdata[ACCEL_W-1:0];
            REG_PULSE_MIN:  pulse_min_ff  <= csr_pwdata[PULSE_W-1:0];
            REG_PULSE_MAX:  pulse_max_ff  <= csr_pwdata[PULSE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_GYRO_BIAS:  csr_prdata = {{(CSR_DATA_W-GYRO_W){gyro_bias_ff[GYRO_W-1]}},
                                       gyro_bias_ff};
         REG_ACCEL_BIAS: csr_prdata = {{(CSR_DATA_W-ACCEL_W){accel_bias_ff[ACCEL_W-1]}},
                                       accel_bias_ff};
         REG_PULSE_MIN:  csr_prdata = {{(CSR_DATA_W-PULSE_W){1'b0}}, pulse_min_ff};
         REG_PULSE_MAX:  csr_prdata = {{(CSR_DATA_W-PULSE_W){1'b0}}, pulse_max_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- front end
   logic     step_valid;
   logic     step_ready;
   step_type step;

   hhdr_step u_step (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .gyro_raw      (req_tdata[15:0]),
      .accel_raw     (req_tdata[31:16]),
      .base_pulse_us (req_tdata[46:32]),
      .gyro_bias     (gyro_bias_ff),
      .accel_bias    (accel_bias_ff),
      .out_valid     (step_valid),
      .out_ready     (step_ready),
      .out_step      (step)
   );

   // ---------------------------------------------------------------- integrators
   logic                      int_valid_ff;
   logic                      out_valid_ff;
   logic                      int_ready;
   logic                      out_ready;
   logic                      int_load;

   logic signed [YAW_W-1:0]   yaw_ff;
   logic signed [SPEED_W-1:0] speed_ff;
   logic signed [DIST_W-1:0]  dist_ff;
   logic signed [SUM_W-1:0]   total_ff;
   logic signed [YAW_W-1:0]   ring_ff [WINDOW_DEPTH];
   logic [IDX_W-1:0]          idx_ff;
   logic [PULSE_W-1:0]        int_base_ff;
   logic                      int_moving_ff;
   logic                      int_mean_upd_ff;

   logic signed [YAW_W:0]     yaw_sum;
   logic signed [YAW_W:0]     yaw_wrap;
   logic signed [YAW_W-1:0]   yaw_in;
   logic signed [SPEED_W:0]   speed_sum;
   logic signed [SPEED_W-1:0] speed_sat;
   logic signed [SPEED_W-1:0] speed_clip;
   logic signed [SPEED_W-1:0] speed_in;
   logic signed [DIST_W+2:0]  five_v;
   logic signed [DIST_W+2:0]  dist_sum;
   logic signed [DIST_W-1:0]  dist_sat;
   logic signed [DIST_W-1:0]  dist_in;
   logic signed [YAW_W-1:0]   ring_old;
   logic signed [SUM_W-1:0]   total_in;
   logic [IDX_W-1:0]          idx_in;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign int_ready  = !int_valid_ff || out_ready;
   assign step_ready = int_ready;
   assign int_load   = step_valid && int_ready;

   assign yaw_sum = $signed({yaw_ff[YAW_W-1], yaw_ff})
                  + $signed({{(YAW_W+1-YAW_STEP_W){step.yaw_step[YAW_STEP_W-1]}},
                             step.yaw_step});

   // one wrap is enough: a step is far below half a turn
   always_comb begin
      yaw_wrap = yaw_sum;
      if (yaw_sum < -YAW_HALF_TURN) begin
         yaw_wrap = yaw_sum + YAW_FULL_TURN;
      end else if (yaw_sum > YAW_HALF_TURN) begin
         yaw_wrap = yaw_sum - YAW_FULL_TURN;
      end
   end
   assign yaw_in = yaw_wrap[YAW_W-1:0];

   assign speed_sum = $signed({speed_ff[SPEED_W-1], speed_ff})
                    + $signed({{(SPEED_W+1-SPEED_STEP_W){step.speed_step[SPEED_STEP_W-1]}},
                               step.speed_step});

   always_comb begin
      if (speed_sum[SPEED_W] != speed_sum[SPEED_W-1]) begin
         speed_sat = speed_sum[SPEED_W] ? {1'b1, {(SPEED_W-1){1'b0}}}
                                        : {1'b0, {(SPEED_W-1){1'b1}}};
      end else begin
         speed_sat = speed_sum[SPEED_W-1:0];
      end
      if ((speed_sat >= -SPEED_FLOOR) && (speed_sat <= SPEED_FLOOR)) begin
         speed_clip = '0;
      end else begin
         speed_clip = speed_sat;
      end
   end

   // distance advances by 5 * speed per beat while moving
   assign five_v   = $signed({{3{speed_clip[SPEED_W-1]}}, speed_clip})
                   + $signed({speed_clip[SPEED_W-1], speed_clip, 2'b00});
   assign dist_sum = $signed({{3{dist_ff[DIST_W-1]}}, dist_ff}) + five_v;

   always_comb begin
      if ((dist_sum[DIST_W+2:DIST_W-1] != 4'b0000) &&
          (dist_sum[DIST_W+2:DIST_W-1] != 4'b1111)) begin
         dist_sat = dist_sum[DIST_W+2] ? {1'b1, {(DIST_W-1){1'b0}}}
                                       : {1'b0, {(DIST_W-1){1'b1}}};
      end else begin
         dist_sat = dist_sum[DIST_W-1:0];
      end
   end

   assign speed_in = step.moving ? speed_clip : '0;
   assign dist_in  = step.moving ? dist_sat : dist_ff;

   // running total of the ring: swap the outgoing slot for the new yaw
   assign ring_old = ring_ff[idx_ff];
   assign total_in = total_ff
                   - $signed({{(SUM_W-YAW_W){ring_old[YAW_W-1]}}, ring_old})
                   + $signed({{(SUM_W-YAW_W){yaw_in[YAW_W-1]}}, yaw_in});
   assign idx_in   = (idx_ff == LAST_SLOT) ? '0 : idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         int_valid_ff <= 1'b0;
         yaw_ff       <= '0;
         speed_ff     <= '0;
         dist_ff      <= '0;
         total_ff     <= '0;
         idx_ff       <= '0;
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         if (int_ready) begin
            int_valid_ff <= step_valid;
         end
         if (int_load) begin
            yaw_ff          <= yaw_in;
            speed_ff        <= speed_in;
            dist_ff         <= dist_in;
            total_ff        <= total_in;
            ring_ff[idx_ff] <= yaw_in;
            idx_ff          <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (int_load) begin
         int_base_ff     <= step.base_us;
         int_moving_ff   <= step.moving;
         int_mean_upd_ff <= (idx_ff == '0);
      end
   end

   // ---------------------------------------------------------------- output stage
   logic signed [YAW_W+5:0]  servo_prod;
   logic [YAW_W+5:0]         servo_mag;
   logic [PULSE_W-1:0]       corr_mag;
   logic signed [PULSE_W+1:0] corr;
   logic signed [PULSE_W+1:0] pulse_raw;
   logic signed [PULSE_W+1:0] pulse_lo;
   logic signed [PULSE_W+1:0] pulse_cl;
   logic signed [PULSE_W+1:0] pulse_min_s;
   logic signed [PULSE_W+1:0] pulse_max_s;
   logic                     lamp_in;
   logic [SUM_W-1:0]         total_mag;
   logic [MEAN_X_W-1:0]      mean_x;
   logic [MEAN_X_W+MEAN_K_W-1:0] mean_prod;
   logic [YAW_W-1:0]         mean_q;
   logic signed [YAW_W-1:0]  mean_in;

   logic [TICKS_W-1:0]       ticks_ff;
   logic signed [YAW_W-1:0]  heading_ff;
   logic signed [DIST_W-1:0] travel_ff;
   logic signed [YAW_W-1:0]  mean_ff;
   logic                     moving_ff;
   logic                     lamp_ff;

   // yaw * 40, then divide by 65536 toward zero
   assign servo_prod = $signed({yaw_ff[YAW_W-1], yaw_ff, 5'b00000})
                     + $signed({{3{yaw_ff[YAW_W-1]}}, yaw_ff, 3'b000});
   assign servo_mag  = servo_prod[YAW_W+5] ? -servo_prod : servo_prod;
   assign corr_mag   = servo_mag[SERVO_SHIFT +: PULSE_W];
   assign corr       = servo_prod[YAW_W+5] ? -$signed({2'b00, corr_mag})
                                           : $signed({2'b00, corr_mag});
   assign pulse_raw  = $signed({2'b00, int_base_ff}) + corr;
   assign pulse_min_s = $signed({2'b00, pulse_min_ff});
   assign pulse_max_s = $signed({2'b00, pulse_max_ff});

   // min first, then max, so the upper limit wins when they cross
   assign pulse_lo = (pulse_raw < pulse_min_s) ? pulse_min_s : pulse_raw;
   assign pulse_cl = (pulse_lo > pulse_max_s) ? pulse_max_s : pulse_lo;

   assign lamp_in = (yaw_ff > -YAW_LAMP_LIMIT) && (yaw_ff < YAW_LAMP_LIMIT);

   // mean = round(total / depth) = floor((2|total| + depth) / (2 * depth))
   assign total_mag = total_ff[SUM_W-1] ? -total_ff : total_ff;
   assign mean_x    = {total_mag, 1'b0} + MEAN_X_W'(WINDOW_DEPTH);
   assign mean_prod = mean_x * MEAN_RECIP;
   assign mean_q    = mean_prod[MEAN_SHIFT +: YAW_W];
   assign mean_in   = total_ff[SUM_W-1] ? -mean_q : mean_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         mean_ff      <= '0;
      end else if (out_ready) begin
         out_valid_ff <= int_valid_ff;
         if (int_valid_ff && int_mean_upd_ff) begin
            mean_ff <= mean_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && int_valid_ff) begin
         ticks_ff   <= {pulse_cl[PULSE_W-1:0], 1'b0};
         heading_ff <= yaw_ff;
         travel_ff  <= dist_ff;
         moving_ff  <= int_moving_ff;
         lamp_ff    <= lamp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, lamp_ff, moving_ff, mean_ff, travel_ff, heading_ff, ticks_ff};

endmodule

// ----- hdl/hhdr_checker.sv -----
// Port-level checker for the heading hold core, bound to the top level.
`timescale 1ns / 1ps

module hhdr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [hhdr_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import hhdr_pkg::*;

   logic signed [YAW_W-1:0] heading;
   logic signed [YAW_W-1:0] heading_mean;

   assign heading      = rsp_tdata[HEADING_LSB +: YAW_W];
   assign heading_mean = rsp_tdata[MEAN_LSB +: YAW_W];

   // reset empties the pipeline
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed");

   // request side only backs up once every stage down to the output holds a beat
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled with room in the pipeline");

   a_angles_wrapped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (heading >= -YAW_HALF_TURN) && (heading <= YAW_HALF_TURN)
                  && (heading_mean >= -YAW_HALF_TURN) && (heading_mean <= YAW_HALF_TURN))
      else $error("heading or mean outside half a turn");

   a_ticks_even: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[TICKS_LSB])
      else $error("servo ticks not a whole microsecond");

endmodule

bind heading_hold_dead_reckoning_core hhdr_checker u_checker (.*);

// ----- tb/heading_hold_dead_reckoning_core_tb.sv -----
// Stream-level testbench for the heading hold and dead reckoning core with a cycle-free predictor.
`timescale 1ns / 1ps

module heading_hold_dead_reckoning_core_tb;
   import hhdr_pkg::*;

   localparam int      RING_DEPTH    = 10;
   localparam int      SETTLE_CYCLES = 8;
   localparam longint  HALF_TURN     = 64'sd11796480;
   localparam longint  FULL_TURN     = 64'sd23592960;
   localparam longint  LAMP_LIMIT    = 64'sd4849664;
   localparam longint  I32_MAX       = 64'sd2147483647;
   localparam longint  I32_MIN       = -64'sd2147483648;
   localparam int      LIMIT_NS      = 2_000_000;

   typedef struct packed {
      logic signed [GYRO_W-1:0]  gyro;
      logic signed [ACCEL_W-1:0] accel;
      logic [PULSE_W-1:0]        base_us;
   } nav_sample_type;

   typedef struct packed {
      logic [TICKS_W-1:0]       ticks;
      logic signed [YAW_W-1:0]  heading;
      logic signed [DIST_W-1:0] travel;
      logic signed [YAW_W-1:0]  mean;
      logic                     moving;
      logic                     lamp;
   } nav_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   heading_hold_dead_reckoning_core #(.WINDOW_DEPTH(RING_DEPTH)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // predictor copy of the registers and navigation state
   logic signed [15:0] gyro_bias_cfg  = '0;
   logic signed [15:0] accel_bias_cfg = '0;
   logic [14:0]        pulse_min_cfg  = 15'd500;
   logic [14:0]        pulse_max_cfg  = 15'd2550;
   longint             yaw_acc   = 0;
   longint             speed_acc = 0;
   longint             dist_acc  = 0;
   longint             yaw_ring [RING_DEPTH];
   int                 ring_slot = 0;
   longint             mean_acc  = 0;

   nav_result_type awaited [$];
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int unsigned hold_left = 0;
   int          mismatches = 0;
   int          samples_sent = 0;
   int          results_checked = 0;

   initial foreach (yaw_ring[i]) yaw_ring[i] = 0;

   function automatic longint round_div(input longint num, input longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q   = (2 * mag + den) / (2 * den);
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint clip32(input longint v);
      if (v > I32_MAX) return I32_MAX;
      if (v < I32_MIN) return I32_MIN;
      return v;
   endfunction

   // advances the navigation state by one sample and returns the beat it should produce
   function automatic nav_result_type dead_reckon_step(input nav_sample_type s);
      longint d, e, dmag, emag, yaw, prod, corr, pulse, v, sum;
      logic   moving;
      nav_result_type r;
      d    = longint'(s.gyro) - longint'(gyro_bias_cfg);
      e    = longint'(s.accel) - longint'(accel_bias_cfg);
      dmag = (d < 0) ? -d : d;
      emag = (e < 0) ? -e : e;
      yaw  = yaw_acc;
      if (dmag > 13) yaw += round_div(d * 16384, 655);
      if (yaw < -HALF_TURN) yaw += FULL_TURN;
      if (yaw > HALF_TURN) yaw -= FULL_TURN;
      yaw     = clip32(yaw);
      yaw_acc = yaw;

      prod  = yaw * 40;
      corr  = (prod < 0) ? -((-prod) / 65536) : prod / 65536;
      pulse = longint'(s.base_us) + corr;
      if (pulse < longint'(pulse_min_cfg)) pulse = pulse_min_cfg;
      if (pulse > longint'(pulse_max_cfg)) pulse = pulse_max_cfg;

      moving = (emag >= 1311) || (dmag >= 79);
      if (moving) begin
         v = speed_acc;
         if (emag > 334) v += round_div(e * 196133, 100000);
         v = clip32(v);
         if (v <= 65 && v >= -65) v = 0;
         speed_acc = v;
         dist_acc  = clip32(dist_acc + 5 * v);
      end else begin
         speed_acc = 0;
      end

      if (ring_slot >= RING_DEPTH) ring_slot = 0;
      yaw_ring[ring_slot] = yaw;
      if (ring_slot == 0) begin
         sum = 0;
         foreach (yaw_ring[i]) sum += yaw_ring[i];
         mean_acc = round_div(sum, RING_DEPTH);
      end
      ring_slot = (ring_slot + 1) % RING_DEPTH;

      r.ticks   = TICKS_W'(pulse * 2);
      r.heading = YAW_W'(yaw);
      r.travel  = DIST_W'(dist_acc);
      r.mean    = YAW_W'(mean_acc);
      r.moving  = moving;
      r.lamp    = (((yaw < 0) ? -yaw : yaw) < LAMP_LIMIT);
      return r;
   endfunction

   function automatic int spread(input int mag);
      return int'($urandom_range(2 * mag)) - mag;
   endfunction

   function automatic logic signed [15:0] to_raw(input int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   // receiver: random stalls, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      nav_result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ticks   = rsp_tdata[TICKS_LSB +: TICKS_W];
         got.heading = rsp_tdata[HEADING_LSB +: YAW_W];
         got.travel  = rsp_tdata[TRAVEL_LSB +: DIST_W];
         got.mean    = rsp_tdata[MEAN_LSB +: YAW_W];
         got.moving  = rsp_tdata[MOVING_BIT];
         got.lamp    = rsp_tdata[LAMP_BIT];
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response beat with nothing outstanding", $realtime);
         end else begin
            want = awaited.pop_front();
            results_checked++;
            if (got.ticks !== want.ticks || got.heading !== want.heading ||
                got.travel !== want.travel || got.mean !== want.mean ||
                got.moving !== want.moving || got.lamp !== want.lamp) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: beat %0d exp/got ticks %0d/%0d heading %0d/%0d travel %0d/%0d",
                           $realtime, results_checked, want.ticks, got.ticks,
                           want.heading, got.heading, want.travel, got.travel);
                  $display("   mean %0d/%0d moving %b/%b lamp %b/%b",
                           want.mean, got.mean, want.moving, got.moving,
                           want.lamp, got.lamp);
               end
            end
         end
      end
   end

   task automatic send_sample(input nav_sample_type s);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, s.base_us, s.accel, s.gyro};
      do @(posedge clock); while (!req_tready);
      awaited.push_back(dead_reckon_step(s));
      samples_sent++;
   endtask

   task automatic send_fields(input int gyro, input int accel, input int base_us);
      nav_sample_type s;
      s.gyro    = to_raw(gyro);
      s.accel   = to_raw(accel);
      s.base_us = 15'(base_us);
      send_sample(s);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_GYRO_BIAS:  gyro_bias_cfg  = val[15:0];
         REG_ACCEL_BIAS: accel_bias_cfg = val[15:0];
         REG_PULSE_MIN:  pulse_min_cfg  = val[14:0];
         REG_PULSE_MAX:  pulse_max_cfg  = val[14:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int gb, input int ab, input int pmin, input int pmax);
      wait_drained();
      write_csr(REG_GYRO_BIAS, 32'(gb));
      write_csr(REG_ACCEL_BIAS, 32'(ab));
      write_csr(REG_PULSE_MIN, 32'(pmin));
      write_csr(REG_PULSE_MAX, 32'(pmax));
   endtask

   // runs of stationary jitter, steady manoeuvres and raw noise
   task automatic run_random(input int count);
      int left, len, kind, turn, push, k;
      nav_sample_type s;
      left = count;
      while (left > 0) begin
         kind = $urandom_range(9);
         len  = $urandom_range(4, 30);
         if (len > left) len = left;
         turn = spread(3000);
         push = spread(8000);
         for (k = 0; k < len; k++) begin
            if (kind < 4) begin
               s.gyro  = to_raw(gyro_bias_cfg + spread(90));
               s.accel = to_raw(accel_bias_cfg + spread(1400));
            end else if (kind < 8) begin
               s.gyro  = to_raw(gyro_bias_cfg + turn + spread(40));
               s.accel = to_raw(accel_bias_cfg + push + spread(200));
            end else begin
               s.gyro  = 16'($urandom);
               s.accel = 16'($urandom);
            end
            s.base_us = ($urandom_range(4) != 0) ? 15'($urandom_range(900, 2100))
                                                 : 15'($urandom_range(20000));
            send_sample(s);
         end
         left -= len;
         if ($urandom_range(39) == 0) wait_drained();
      end
   endtask

   // deadband and motion thresholds either side, field extremes, pulse clamps
   task automatic test_boundaries();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_fields(0, 0, 1500);
      send_fields(13, 334, 1500);
      send_fields(14, 335, 1500);
      send_fields(-13, -334, 1500);
      send_fields(-14, -335, 1500);
      send_fields(78, 1310, 1500);
      send_fields(79, 0, 1500);
      send_fields(0, 1311, 1500);
      // near-cancelling step drops speed under the floor
      send_fields(-79, -1300, 1500);
      send_fields(32767, 32767, 20000);
      send_fields(-32768, -32768, 0);
      send_fields(0, 0, 16384);
   endtask

   // full-scale gyro through both wrap points, lamp going off and on
   task automatic test_heading_wrap();
      set_config(-32768, 0, 500, 2550);
      repeat (8) send_fields(32767, 0, 1500);
      set_config(32767, 0, 500, 2550);
      repeat (8) send_fields(-32768, 0, 1500);
   endtask

   // long receiver hold-off while samples keep coming, then a full drain
   task automatic test_backpressure();
      set_config(0, 0, 500, 2550);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_left <= 300;
      repeat (30) send_fields(spread(2000), spread(4000), $urandom_range(20000));
      wait_drained();
   endtask

   task automatic test_flow_phases();
      set_config(spread(200), spread(200), 500, 2550);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random(265);
      set_config(-32768, 32767, 0, 20000);
      send_idle_pct = 87;
      run_random(265);
      set_config(32767, -32768, 20000, 0);
      send_idle_pct = 0;
      rsp_stall_pct = 87;
      run_random(265);
      set_config(spread(1000), spread(1000), $urandom_range(20000), $urandom_range(20000));
      send_idle_pct = 25;
      rsp_stall_pct = 25;
      run_random(265);
   endtask

   // sustained full-scale push: travel saturates high within ~85 beats, then low
   task automatic test_travel_limits();
      set_config(0, -32768, 500, 2550);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (100) send_fields(0, 32767, $urandom_range(20000));
      send_fields(0, -32768, 1500);
      set_config(0, 32767, 500, 2550);
      repeat (130) send_fields(0, -32768, $urandom_range(20000));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_boundaries();
      test_heading_wrap();
      test_backpressure();
      test_flow_phases();
      test_travel_limits();
      wait_drained();
      $display("%0d samples in, %0d result beats checked: thresholds, heading wrap, clamps,",
               samples_sent, results_checked);
      $display("receiver hold-off, four flow-control mixes and travel saturation both ways");
      if (mismatches == 0 && awaited.size() == 0)
         $display("[heading_hold_dead_reckoning_core] OK");
      else
         $display("[heading_hold_dead_reckoning_core] ERROR");
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("[heading_hold_dead_reckoning_core] ERROR");
      $finish;
   end

endmodule
